>>> rtl/bte_pkg.sv
package bte_pkg;

   localparam int BytesPerLine = 16;
   localparam int BurstMax     = 7;
   localparam int BurstCntW    = 3;

   typedef enum logic [1:0] {
      MODE_BASE64 = 2'd0,
      MODE_HEX    = 2'd1,
      MODE_LIST   = 2'd2,
      MODE_RAW    = 2'd3
   } mode_type;

   localparam logic [7:0] ChNewline = 8'h0A;
   localparam logic [7:0] ChSpace   = 8'h20;
   localparam logic [7:0] ChComma   = 8'h2C;
   localparam logic [7:0] ChZero    = 8'h30;
   localparam logic [7:0] ChX       = 8'h78;
   localparam logic [7:0] ChPad     = 8'h3D;
   localparam logic [7:0] ChPlus    = 8'h2B;
   localparam logic [7:0] ChSlash   = 8'h2F;
   localparam logic [7:0] ChUpperA  = 8'h41;
   localparam logic [7:0] ChLowerA  = 8'h61;

   // characters produced by one input word, chars[0] goes out first
   typedef struct packed {
      logic [BurstMax-1:0][7:0] chars;
      logic [BurstCntW-1:0]     count;
      logic                     last;
   } burst_type;

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10) begin
         r = ChZero + {4'h0, v};
      end else begin
         r = ChUpperA + {4'h0, v} - 8'd10;
      end
      return r;
   endfunction

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] r;
      if (v < 6'd26) begin
         r = ChUpperA + {2'b00, v};
      end else if (v < 6'd52) begin
         r = ChLowerA + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         r = ChZero + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         r = ChPlus;
      end else begin
         r = ChSlash;
      end
      return r;
   endfunction

endpackage

>>> rtl/bte_encode.sv
module bte_encode #(
   parameter int BYTES_PER_LINE = bte_pkg::BytesPerLine
) (
   input  logic                clock,
   input  logic                reset,
   input  bte_pkg::mode_type   mode,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                final_byte,
   output bte_pkg::burst_type  burst
);

   localparam int ColW = (BYTES_PER_LINE > 1) ? $clog2(BYTES_PER_LINE) : 1;
   localparam logic [ColW-1:0] ColLast = ColW'(BYTES_PER_LINE - 1);

   logic [1:0]      phase_ff, phase_in;
   logic [15:0]     held_ff, held_in;
   logic [ColW-1:0] col_ff, col_in;
   logic            first_ff, first_in;

   logic [23:0]                   packed_w;
   logic [2:0]                    b64_cnt;
   logic                          b64_emit;
   logic [bte_pkg::BurstCntW-1:0] n;

   always_comb begin
      burst    = '0;
      n        = '0;
      phase_in = phase_ff;
      held_in  = held_ff;
      col_in   = col_ff;
      first_in = first_ff;
      packed_w = '0;
      b64_cnt  = 3'd4;
      b64_emit = 1'b0;

      unique case (mode)
         bte_pkg::MODE_RAW: begin
            burst.chars[n] = data_byte;
            n = n + 1'b1;
         end
         bte_pkg::MODE_HEX: begin
            burst.chars[n] = bte_pkg::hex_char(data_byte[7:4]);
            n = n + 1'b1;
            burst.chars[n] = bte_pkg::hex_char(data_byte[3:0]);
            n = n + 1'b1;
         end
         bte_pkg::MODE_LIST: begin
            if (!first_ff) begin
               if (col_ff == '0) begin
                  burst.chars[n] = bte_pkg::ChNewline;
                  n = n + 1'b1;
               end else begin
                  burst.chars[n] = bte_pkg::ChComma;
                  n = n + 1'b1;
                  burst.chars[n] = bte_pkg::ChSpace;
                  n = n + 1'b1;
               end
            end
            burst.chars[n] = bte_pkg::ChZero;
            n = n + 1'b1;
            burst.chars[n] = bte_pkg::ChX;
            n = n + 1'b1;
            burst.chars[n] = bte_pkg::hex_char(data_byte[7:4]);
            n = n + 1'b1;
            burst.chars[n] = bte_pkg::hex_char(data_byte[3:0]);
            n = n + 1'b1;
            col_in = (col_ff == ColLast) ? '0 : col_ff + 1'b1;
         end
         bte_pkg::MODE_BASE64: begin
            if (phase_ff == 2'd0) begin
               if (final_byte) begin
                  packed_w = {data_byte, 16'h0000};
                  b64_cnt  = 3'd2;
                  b64_emit = 1'b1;
               end else begin
                  held_in  = {8'h00, data_byte};
                  phase_in = 2'd1;
               end
            end else if (phase_ff == 2'd1) begin
               if (final_byte) begin
                  packed_w = {held_ff[7:0], data_byte, 8'h00};
                  b64_cnt  = 3'd3;
                  b64_emit = 1'b1;
               end else begin
                  held_in  = {held_ff[7:0], data_byte};
                  phase_in = 2'd2;
               end
            end else begin
               packed_w = {held_ff, data_byte};
               b64_cnt  = 3'd4;
               b64_emit = 1'b1;
               held_in  = '0;
               phase_in = 2'd0;
            end
            if (b64_emit) begin
               burst.chars[n] = bte_pkg::b64_char(packed_w[23:18]);
               n = n + 1'b1;
               burst.chars[n] = bte_pkg::b64_char(packed_w[17:12]);
               n = n + 1'b1;
               burst.chars[n] = (b64_cnt >= 3'd3) ? bte_pkg::b64_char(packed_w[11:6])
                                                  : bte_pkg::ChPad;
               n = n + 1'b1;
               burst.chars[n] = (b64_cnt >= 3'd4) ? bte_pkg::b64_char(packed_w[5:0])
                                                  : bte_pkg::ChPad;
               n = n + 1'b1;
            end
         end
      endcase

      first_in = 1'b0;
      if (final_byte) begin
         if (mode != bte_pkg::MODE_RAW) begin
            burst.chars[n] = bte_pkg::ChNewline;
            n = n + 1'b1;
         end
         burst.last = 1'b1;
         phase_in   = '0;
         held_in    = '0;
         col_in     = '0;
         first_in   = 1'b1;
      end
      burst.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         held_ff  <= '0;
         col_ff   <= '0;
         first_ff <= 1'b1;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         col_ff   <= col_in;
         first_ff <= first_in;
      end
   end

endmodule

>>> rtl/byte_to_text_export_encoder.sv
// Byte stream to text encoder: base64, continuous hex, wrapped C byte list or raw.
// Input channel req_*: one payload byte per word, req_final_byte marks the last
// byte of a payload. Output channel rsp_*: one character per word, rsp_out_last
// set on the final character of the payload's text.
// Configuration: csr_output_mode is written on csr_valid (csr_ready is always
// high); change it only while the block is idle.
// Output path: a byte's characters reach rsp through the burst register, then
// the output register. Throughput: the characters of one byte are held in the
// burst register and shifted out one per cycle while the receiver takes them.
// A byte makes 1 character in raw mode, 2 in hex (3 on the final byte), up to 7
// in byte-list mode, 0 to 5 in base64. The next byte is taken in the cycle the
// last character of the current burst moves to the output register; a byte
// that makes no character leaves req_ready high.
// Reset clears the mode to base64 and all payload state.
// A stalled receiver holds the output register; the burst waits behind it and
// req_ready drops once the burst cannot drain.
module byte_to_text_export_encoder #(
   parameter int BYTES_PER_LINE = bte_pkg::BytesPerLine
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_output_mode
);

   bte_pkg::mode_type  mode_ff;
   bte_pkg::burst_type burst;
   bte_pkg::burst_type buf_ff;
   logic               busy_ff;
   logic [bte_pkg::BurstCntW-1:0] rem_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_char_ff;
   logic               rsp_last_ff;

   logic accept, out_adv, take, take_last;

   assign csr_ready = 1'b1;
   assign accept    = req_valid & req_ready;
   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign take      = busy_ff && out_adv;
   assign take_last = take && (rem_ff == bte_pkg::BurstCntW'(1));
   assign req_ready = !busy_ff || take_last;

   bte_encode #(
      .BYTES_PER_LINE(BYTES_PER_LINE)
   ) u_encode (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .accept    (accept),
      .data_byte (req_data_byte),
      .final_byte(req_final_byte),
      .burst     (burst)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bte_pkg::MODE_BASE64;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= bte_pkg::mode_type'(csr_output_mode);
      end
   end

   // burst register, shifted toward chars[0]
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rem_ff  <= '0;
      end else if (accept) begin
         busy_ff <= (burst.count != '0);
         rem_ff  <= burst.count;
      end else if (take) begin
         busy_ff <= !take_last;
         rem_ff  <= rem_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff <= burst;
      end else if (take) begin
         buf_ff.chars <= {8'h00, buf_ff.chars[bte_pkg::BurstMax-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_char_ff <= buf_ff.chars[0];
         rsp_last_ff <= buf_ff.last && take_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_out_last = rsp_last_ff;

   a_busy_has_chars: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff != '0)
      else $error("burst busy with no characters left");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept && burst.count != '0 |=> busy_ff)
      else $error("encoded word not held in burst register");

   a_final_closes: assert property (@(posedge clock) disable iff (reset)
      accept && req_final_byte |-> burst.last && burst.count != '0)
      else $error("final byte produced no closing character");

   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      take_last && buf_ff.last |=> rsp_valid_ff && rsp_last_ff)
      else $error("last character not marked on output");

   a_no_take_while_full: assert property (@(posedge clock) disable iff (reset)
      busy_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input taken while burst is stalled");

endmodule

>>> sim/tb_byte_to_text_export_encoder.sv
`timescale 1ns / 1ps

module tb_byte_to_text_export_encoder;

   localparam logic [8*16-1:0] HexDigits = "0123456789ABCDEF";
   localparam logic [8*64-1:0] B64Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } text_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_final_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_out_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_output_mode = 2'd0;

   // predictor state
   bte_pkg::mode_type cur_mode = bte_pkg::MODE_BASE64;
   logic [1:0]  b64_phase = 2'd0;
   logic [15:0] b64_held = 16'h0000;
   int unsigned list_col = 0;
   logic        payload_fresh = 1'b1;

   text_char_type text_due[$];
   text_char_type due_head;
   int unsigned errors = 0;
   int unsigned bytes_sent = 0;
   int unsigned chars_checked = 0;
   int unsigned mode_writes = 0;
   int unsigned rsp_hold_cycles = 0;
   logic        steady = 1'b0;

   byte_to_text_export_encoder DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_final_byte  (req_final_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_out_last    (rsp_out_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_output_mode (csr_output_mode)
   );

   always #6 clock = ~clock;

   function automatic logic [7:0] hex_at(input logic [3:0] v);
      return HexDigits[8*(15-v) +: 8];
   endfunction

   function automatic logic [7:0] b64_at(input logic [5:0] v);
      return B64Alphabet[8*(63-v) +: 8];
   endfunction

   task automatic encode_byte(input logic [7:0] b, input logic fin);
      logic [7:0]    burst[$];
      logic [23:0]   grp;
      int            n_b64;
      text_char_type due_item;
      grp = '0;
      n_b64 = 0;
      case (cur_mode)
         bte_pkg::MODE_RAW: burst = {burst, b};
         bte_pkg::MODE_HEX: begin
            burst = {burst, hex_at(b[7:4])};
            burst = {burst, hex_at(b[3:0])};
         end
         bte_pkg::MODE_LIST: begin
            if (!payload_fresh) begin
               if (list_col == 0) begin
                  burst = {burst, bte_pkg::ChNewline};
               end else begin
                  burst = {burst, bte_pkg::ChComma};
                  burst = {burst, bte_pkg::ChSpace};
               end
            end
            burst = {burst, bte_pkg::ChZero};
            burst = {burst, bte_pkg::ChX};
            burst = {burst, hex_at(b[7:4])};
            burst = {burst, hex_at(b[3:0])};
            list_col = (list_col + 1) % bte_pkg::BytesPerLine;
         end
         default: begin
            if (b64_phase == 2'd0) begin
               if (fin) begin
                  grp = {b, 16'h0000};
                  n_b64 = 2;
               end else begin
                  b64_held = {8'h00, b};
                  b64_phase = 2'd1;
               end
            end else if (b64_phase == 2'd1) begin
               if (fin) begin
                  grp = {b64_held[7:0], b, 8'h00};
                  n_b64 = 3;
               end else begin
                  b64_held = {b64_held[7:0], b};
                  b64_phase = 2'd2;
               end
            end else begin
               grp = {b64_held, b};
               n_b64 = 4;
               b64_held = 16'h0000;
               b64_phase = 2'd0;
            end
            if (n_b64 != 0) begin
               burst = {burst, b64_at(grp[23:18])};
               burst = {burst, b64_at(grp[17:12])};
               burst = {burst, (n_b64 >= 3) ? b64_at(grp[11:6]) : bte_pkg::ChPad};
               burst = {burst, (n_b64 >= 4) ? b64_at(grp[5:0]) : bte_pkg::ChPad};
            end
         end
      endcase
      payload_fresh = 1'b0;
      if (fin) begin
         if (cur_mode != bte_pkg::MODE_RAW) burst = {burst, bte_pkg::ChNewline};
         b64_phase = 2'd0;
         b64_held = 16'h0000;
         list_col = 0;
         payload_fresh = 1'b1;
      end
      foreach (burst[i]) begin
         due_item.ch = burst[i];
         due_item.last = fin && (i == burst.size() - 1);
         text_due = {text_due, due_item};
      end
   endtask

   // one word on the request channel; valid stays high on return
   task automatic send_byte(input logic [7:0] b, input logic fin);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 25) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data_byte = b;
      req_final_byte = fin;
      do @(posedge clock); while (!req_ready);
      encode_byte(b, fin);
      bytes_sent++;
   endtask

   task automatic send_payload(input int len);
      for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), i == len - 1);
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid = 1'b0;
      while (text_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_mode(input bte_pkg::mode_type m);
      drain();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_output_mode = m;
      do @(posedge clock); while (!csr_ready);
      cur_mode = m;
      mode_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // reset mode is base64: padding with one and two bytes, full group with '+' and '/'
   task automatic test_base64_groups;
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hBF, 1'b1);
   endtask

   task automatic test_raw_and_hex;
      set_mode(bte_pkg::MODE_RAW);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      set_mode(bte_pkg::MODE_HEX);
      send_byte(8'h0F, 1'b0);
      send_byte(8'hF0, 1'b1);
   endtask

   // 17 bytes: one full line plus the wrap
   task automatic test_list_wrap;
      set_mode(bte_pkg::MODE_LIST);
      for (int i = 0; i < 17; i++) send_byte(8'(i * 15), i == 16);
   endtask

   // state carries across a mode change inside a payload
   task automatic test_mode_switch;
      set_mode(bte_pkg::MODE_BASE64);
      send_byte(8'hA5, 1'b0);
      set_mode(bte_pkg::MODE_LIST);
      send_byte(8'h5A, 1'b0);
      set_mode(bte_pkg::MODE_BASE64);
      send_byte(8'h3C, 1'b1);
   endtask

   task automatic test_random_payloads(input int target, input logic no_idle);
      int                start;
      int                len;
      int                cut;
      bte_pkg::mode_type m;
      start = bytes_sent;
      steady = no_idle;
      while (bytes_sent - start < target) begin
         m = bte_pkg::mode_type'($urandom_range(0, 3));
         if (m != cur_mode || $urandom_range(0, 3) == 0) set_mode(m);
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : -1;
         for (int i = 0; i < len; i++) begin
            if (i == cut) set_mode(bte_pkg::mode_type'($urandom_range(0, 3)));
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
         end
      end
      steady = 1'b0;
   endtask

   // receiver stalls while bytes keep coming; input must back up
   task automatic test_output_stall;
      set_mode(bte_pkg::MODE_LIST);
      rsp_hold_cycles = 150;
      send_payload(30);
      set_mode(bte_pkg::MODE_HEX);
      rsp_hold_cycles = 80;
      send_payload(12);
   endtask

   always @(negedge clock) begin
      if (rsp_hold_cycles != 0) begin
         rsp_ready = 1'b0;
         rsp_hold_cycles = rsp_hold_cycles - 1;
      end else begin
         rsp_ready = steady || ($urandom_range(0, 99) >= 25);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (text_due.size() == 0) begin
            $error("unexpected word: out_char %h out_last %b", rsp_out_char, rsp_out_last);
            errors++;
         end else begin
            due_head = text_due.pop_front();
            chars_checked++;
            if (rsp_out_char !== due_head.ch) begin
               $error("out_char: expected %h actual %h", due_head.ch, rsp_out_char);
               errors++;
            end
            if (rsp_out_last !== due_head.last) begin
               $error("out_last: expected %b actual %b", due_head.last, rsp_out_last);
               errors++;
            end
         end
      end
   end

   initial begin
      #3000000;
      $display("tb_byte_to_text_export_encoder: errors");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_base64_groups();
      test_raw_and_hex();
      test_list_wrap();
      test_mode_switch();
      test_random_payloads(90, 1'b1);
      test_output_stall();
      test_random_payloads(250, 1'b0);

      drain();
      repeat (10) @(posedge clock);
      if (text_due.size() != 0) begin
         $error("%0d expected words never arrived", text_due.size());
         errors++;
      end
      $display("%0d bytes in, %0d characters checked, %0d mode writes",
               bytes_sent, chars_checked, mode_writes);
      $display("covered all four modes, padding, line wrap, mid-payload mode change, stalls");
      if (errors == 0) begin
         $display("tb_byte_to_text_export_encoder: clean");
      end else begin
         $display("tb_byte_to_text_export_encoder: errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/bte_pkg.sv
rtl/bte_encode.sv
rtl/byte_to_text_export_encoder.sv
sim/tb_byte_to_text_export_encoder.sv
